### sv/idlhl_pkg.sv
// Shared types and codes for the indexed doubly linked handle list.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package idlhl_pkg;

  // Command codes carried on in_command.
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  // Result status codes carried on out_status.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOT_LIVE = 2'd2,
    ST_ZERO     = 2'd3
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    accept;      // Latch the input word.
    logic    clear_step;  // Initialize one table entry.
    logic    ins_link;    // Store the item and link the slot in front of the head.
    logic    ins_head;    // Make the slot the new head.
    logic    rem_unlink;  // Unlink a live slot and take its item.
    logic    rem_free;    // Push the removed slot onto the free list.
    logic    set_fail;    // Record a failed operation.
    status_t fail_code;
    logic    emit;        // Move the result into the output register.
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
    logic in_remove;
    logic item_zero;
    logic table_full;
    logic index_bad;
    logic slot_live;
    logic out_free;
  } stat_t;

endpackage

### sv/idlhl_dp.sv
// Datapath of the indexed doubly linked handle list: the slot memories,
// list head and free head registers, result and output registers.
// Depends on idlhl_pkg.
`timescale 1ns / 1ps

module idlhl_dp
  import idlhl_pkg::*;
#(
  parameter int SLOTS     = 256,
  parameter int ITEM_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output stat_t       stat,
  input  logic        in_command,
  input  logic [31:0] in_item_value,
  input  logic [7:0]  in_entry_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [7:0]  out_slot_index,
  output logic [31:0] out_removed_item
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int SW    = (ITEM_BITS < 32) ? ITEM_BITS : 32;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(SLOTS - 1);

  logic [SW-1:0]    item_mem [SLOTS];
  logic [IDX_W-1:0] next_mem [SLOTS];
  logic [IDX_W-1:0] prev_mem [SLOTS];

  logic [SW-1:0]    rd_item;
  logic [IDX_W-1:0] rd_next, rd_prev, rd_addr;

  logic             item_we, next_we, prev_we;
  logic [IDX_W-1:0] item_wa, next_wa, prev_wa;
  logic [SW-1:0]    item_wd;
  logic [IDX_W-1:0] next_wd, prev_wd;

  logic [IDX_W-1:0] clr_cnt_r, clr_cnt_nxt, clr_link;
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0] free_r, free_nxt;
  logic [IDX_W-1:0] idx_r;
  logic [SW-1:0]    item_r;

  status_t          res_status_r;
  logic [7:0]       res_slot_r;
  logic [31:0]      res_item_r;
  logic             out_valid_r;
  logic [1:0]       out_status_r;
  logic [7:0]       out_slot_r;
  logic [31:0]      out_item_r;

  // The read port follows the input word, so the entry needed by the next
  // operation is already in the read register in the cycle after acceptance.
  assign rd_addr = (in_command == CMD_REMOVE) ? IDX_W'(in_entry_index) : free_r;

  assign clr_link = (clr_cnt_r == LAST) ? '0 : clr_cnt_r + 1'b1;

  assign stat.clear_last = (clr_cnt_r == LAST);
  assign stat.in_remove  = (in_command == CMD_REMOVE);
  assign stat.item_zero  = (in_item_value[SW-1:0] == '0);
  assign stat.table_full = (free_r == '0);
  assign stat.index_bad  = (32'(in_entry_index) >= 32'(SLOTS));
  assign stat.slot_live  = (rd_item != '0);
  assign stat.out_free   = !out_valid_r || !out_stall;

  always_comb begin
    item_we  = 1'b0;
    item_wa  = idx_r;
    item_wd  = '0;
    next_we  = 1'b0;
    next_wa  = idx_r;
    next_wd  = '0;
    prev_we  = 1'b0;
    prev_wa  = idx_r;
    prev_wd  = '0;
    head_nxt = head_r;
    free_nxt = free_r;
    if (cmd.clear_step) begin
      item_we = 1'b1;
      item_wa = clr_cnt_r;
      next_we = 1'b1;
      next_wa = clr_cnt_r;
      next_wd = clr_link;
      prev_we = 1'b1;
      prev_wa = clr_cnt_r;
    end else if (cmd.ins_link) begin
      item_we  = 1'b1;
      item_wd  = item_r;
      next_we  = 1'b1;
      next_wd  = head_r;
      prev_we  = 1'b1;
      prev_wa  = head_r;
      prev_wd  = idx_r;
      free_nxt = rd_next;
    end else if (cmd.ins_head) begin
      prev_we  = 1'b1;
      head_nxt = idx_r;
    end else if (cmd.rem_unlink) begin
      item_we = 1'b1;
      prev_we = 1'b1;
      prev_wa = rd_next;
      prev_wd = rd_prev;
      if (rd_prev == '0) begin
        head_nxt = rd_next;
      end else begin
        next_we = 1'b1;
        next_wa = rd_prev;
        next_wd = rd_next;
      end
    end else if (cmd.rem_free) begin
      next_we  = 1'b1;
      next_wd  = free_r;
      free_nxt = idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (item_we) begin
      item_mem[item_wa] <= item_wd;
    end
    rd_item <= item_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (next_we) begin
      next_mem[next_wa] <= next_wd;
    end
    rd_next <= next_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (prev_we) begin
      prev_mem[prev_wa] <= prev_wd;
    end
    rd_prev <= prev_mem[rd_addr];
  end

  assign clr_cnt_nxt = cmd.clear_step ? clr_link : clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      head_r      <= '0;
      free_r      <= IDX_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      clr_cnt_r <= clr_cnt_nxt;
      head_r    <= head_nxt;
      free_r    <= free_nxt;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      idx_r  <= (in_command == CMD_REMOVE) ? IDX_W'(in_entry_index) : free_r;
      item_r <= in_item_value[SW-1:0];
    end
    if (cmd.set_fail) begin
      res_status_r <= cmd.fail_code;
      res_slot_r   <= '0;
      res_item_r   <= '0;
    end else if (cmd.ins_link) begin
      res_status_r <= ST_OK;
      res_slot_r   <= 8'(idx_r);
      res_item_r   <= '0;
    end else if (cmd.rem_unlink) begin
      res_status_r <= ST_OK;
      res_slot_r   <= '0;
      res_item_r   <= 32'(rd_item);
    end
    if (cmd.emit) begin
      out_status_r <= res_status_r;
      out_slot_r   <= res_slot_r;
      out_item_r   <= res_item_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_slot_index   = out_slot_r;
  assign out_removed_item = out_item_r;

endmodule

### sv/idlhl_ctrl.sv
// Controller of the indexed doubly linked handle list: sequences the
// clearing pass and the insert and remove steps. Depends on idlhl_pkg.
`timescale 1ns / 1ps

module idlhl_ctrl
  import idlhl_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_INS_LINK,
    S_INS_HEAD,
    S_REM_CHECK,
    S_REM_FREE,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   can_take;

  assign can_take = (state_r == S_IDLE) || (state_r == S_DONE && stat.out_free);
  assign in_stall = !can_take;

  always_comb begin
    cmd       = '0;
    cmd.fail_code = ST_OK;
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_INS_LINK: begin
        cmd.ins_link = 1'b1;
        state_nxt    = S_INS_HEAD;
      end
      S_INS_HEAD: begin
        cmd.ins_head = 1'b1;
        state_nxt    = S_DONE;
      end
      S_REM_CHECK: begin
        if (stat.slot_live) begin
          cmd.rem_unlink = 1'b1;
          state_nxt      = S_REM_FREE;
        end else begin
          cmd.set_fail  = 1'b1;
          cmd.fail_code = ST_NOT_LIVE;
          state_nxt     = S_DONE;
        end
      end
      S_REM_FREE: begin
        cmd.rem_free = 1'b1;
        state_nxt    = S_DONE;
      end
      S_IDLE, S_DONE: begin
        if (state_r == S_DONE && stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
        if (can_take && in_valid) begin
          cmd.accept = 1'b1;
          if (stat.in_remove) begin
            if (stat.index_bad) begin
              cmd.set_fail  = 1'b1;
              cmd.fail_code = ST_NOT_LIVE;
              state_nxt     = S_DONE;
            end else begin
              state_nxt = S_REM_CHECK;
            end
          end else if (stat.item_zero) begin
            cmd.set_fail  = 1'b1;
            cmd.fail_code = ST_ZERO;
            state_nxt     = S_DONE;
          end else if (stat.table_full) begin
            cmd.set_fail  = 1'b1;
            cmd.fail_code = ST_FULL;
            state_nxt     = S_DONE;
          end else begin
            state_nxt = S_INS_LINK;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### sv/indexed_doubly_linked_handle_list.sv
// Fixed-capacity handle table of SLOTS slots. A head register points at a
// doubly linked list of live slots whose ends link to slot 0, and free
// slots form a singly linked free list. An insert stores a nonzero item in
// the head free slot, links it at the list head and returns the slot index;
// a remove unlinks a live slot, returns its item and frees the slot. Each
// runs through the dependent accesses of the link memories (one read, then
// two writes to the single write port of each link memory) before the next
// word is taken; a remove of a free slot ends after the read, and a refused
// word (zero item, full table, index out of range) goes straight to its
// result. After reset the block initializes the slot memories, one entry
// per cycle, and holds in_stall high during that pass. A finished result
// waits in an output register, so the next word is accepted while it is
// stalled. Depends on idlhl_pkg, idlhl_ctrl and idlhl_dp.
`timescale 1ns / 1ps

module indexed_doubly_linked_handle_list
  import idlhl_pkg::*;
#(
  parameter int SLOTS     = 256,
  parameter int ITEM_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_command,
  input  logic [31:0] in_item_value,
  input  logic [7:0]  in_entry_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [7:0]  out_slot_index,
  output logic [31:0] out_removed_item
);

  cmd_t  cmd;
  stat_t stat;

  // The controller decides the sequence of steps for each word; the
  // datapath owns every memory and register that holds table state.
  idlhl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  idlhl_dp #(
    .SLOTS     (SLOTS),
    .ITEM_BITS (ITEM_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_command       (in_command),
    .in_item_value    (in_item_value),
    .in_entry_index   (in_entry_index),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_slot_index   (out_slot_index),
    .out_removed_item (out_removed_item)
  );

  // No word may enter while the memories are still being initialized.
  a_clear_blocks_input: assert property (
    @(posedge clk) disable iff (!rst_n) cmd.clear_step |-> in_stall
  ) else $error("word accepted during the clearing pass");

  // The datapath carries out at most one table update per cycle.
  a_one_update: assert property (
    @(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.clear_step, cmd.ins_link, cmd.ins_head, cmd.rem_unlink, cmd.rem_free})
  ) else $error("more than one table update in a cycle");

  // A refused word reports an empty slot index and no item.
  a_fail_payload: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_slot_index == 8'd0 && out_removed_item == 32'd0)
  ) else $error("failed result carries a payload");

  // A successful result names a real slot or returns a nonzero item.
  a_ok_payload: assert property (
    @(posedge clk) disable iff (!rst_n)
    (SLOTS <= 256 && out_valid && out_status == ST_OK)
      |-> (out_slot_index != 8'd0 || out_removed_item != 32'd0)
  ) else $error("successful result with neither slot nor item");

endmodule

### tb/indexed_doubly_linked_handle_list_test.sv
// Self-checking test of the indexed doubly linked handle list: random and directed
// insert/remove words are checked against a cycle-free predictor of the slot table.
// Depends on idlhl_pkg and indexed_doubly_linked_handle_list.
`timescale 1ns / 1ps

module indexed_doubly_linked_handle_list_test;
  import idlhl_pkg::*;

  // Words sent in the random part, and the longest run of cycles without
  // any handshake before the run is declared hung. The limit covers the
  // clearing pass after reset plus the worst sender gap, receiver stall and
  // block latency several times over.
  localparam int RANDOM_WORDS = 1030;
  localparam int HANG_LIMIT   = 2000;
  localparam int LAST_SLOT    = 255;

  // One expected result word.
  typedef struct packed {
    status_t     status;
    logic [7:0]  slot;
    logic [31:0] item;
  } table_reply_t;

  // Scoreboard: it keeps its own copy of the slot table, works out the
  // reply to every accepted command and checks result words in order.
  class handle_table_board;
    logic [31:0]  held_item [256];
    logic [7:0]   fwd_link  [256];
    logic [7:0]   back_link [256];
    logic [7:0]   free_top;
    int           live_count;
    int           failures;
    table_reply_t pending_replies[$];

    function new();
      for (int i = 0; i < 256; i++) begin
        held_item[i] = 32'd0;
        back_link[i] = 8'd0;
        fwd_link[i]  = (i == 0 || i == LAST_SLOT) ? 8'd0 : 8'(i + 1);
      end
      free_top   = 8'd1;
      live_count = 0;
      failures   = 0;
    endfunction

    // Applies one command to the table copy and returns the reply it causes.
    function table_reply_t apply_command(logic cmd, logic [31:0] item, logic [7:0] idx);
      table_reply_t r;
      logic [7:0]   slot;
      logic [7:0]   after;
      logic [7:0]   nx;
      logic [7:0]   pv;
      r.status = ST_OK;
      r.slot   = 8'd0;
      r.item   = 32'd0;
      if (cmd == CMD_INSERT) begin
        if (item == 32'd0) begin
          r.status = ST_ZERO;
        end else if (free_top == 8'd0) begin
          r.status = ST_FULL;
        end else begin
          slot            = free_top;
          after           = fwd_link[0];
          free_top        = fwd_link[slot];
          held_item[slot] = item;
          fwd_link[slot]  = after;
          fwd_link[0]     = slot;
          back_link[slot] = 8'd0;
          back_link[after] = slot;
          r.slot          = slot;
          live_count++;
        end
      end else begin
        if (held_item[idx] == 32'd0) begin
          r.status = ST_NOT_LIVE;
        end else begin
          nx            = fwd_link[idx];
          pv            = back_link[idx];
          back_link[nx] = pv;
          fwd_link[pv]  = nx;
          r.item        = held_item[idx];
          held_item[idx] = 32'd0;
          fwd_link[idx] = free_top;
          free_top      = idx;
          live_count--;
        end
      end
      return r;
    endfunction

    function void note_command(logic cmd, logic [31:0] item, logic [7:0] idx);
      pending_replies.push_back(apply_command(cmd, item, idx));
    endfunction

    function void check_reply(logic [1:0] st, logic [7:0] slot, logic [31:0] item);
      table_reply_t want;
      if (pending_replies.size() == 0) begin
        $error("result word with nothing outstanding: status %0d slot %0d item %h",
               st, slot, item);
        failures++;
        return;
      end
      want = pending_replies.pop_front();
      if (st !== want.status) begin
        $error("field status: expected %0d, actual %0d", want.status, st);
        failures++;
      end
      if (slot !== want.slot) begin
        $error("field slot_index: expected %0d, actual %0d", want.slot, slot);
        failures++;
      end
      if (item !== want.item) begin
        $error("field removed_item: expected %h, actual %h", want.item, item);
        failures++;
      end
    endfunction

    // Picks a random live slot, if there is one.
    function bit pick_live_slot(output logic [7:0] slot);
      int start;
      start = $urandom_range(LAST_SLOT, 1);
      slot  = 8'd0;
      for (int k = 0; k < LAST_SLOT; k++) begin
        slot = 8'((start - 1 + k) % LAST_SLOT + 1);
        if (held_item[slot] != 32'd0) return 1'b1;
      end
      return 1'b0;
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_command;
  logic [31:0] in_item_value;
  logic [7:0]  in_entry_index;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_status;
  logic [7:0]  out_slot_index;
  logic [31:0] out_removed_item;

  handle_table_board board;

  // When a rush flag is set, that side runs with no idle cycles at all, so
  // back-to-back traffic is covered as well as the gapped kind.
  bit sender_rush;
  bit receiver_rush;
  int words_sent;

  indexed_doubly_linked_handle_list i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_item_value    (in_item_value),
    .in_entry_index   (in_entry_index),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_slot_index   (out_slot_index),
    .out_removed_item (out_removed_item)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Presents one command word after a random gap and holds it until the
  // block takes it. Valid stays high across back-to-back words, so it gets
  // only one assignment per time step.
  task automatic send_word(input logic cmd, input logic [31:0] item, input logic [7:0] idx);
    int gap;
    if ($urandom_range(39, 0) == 0) sender_rush = ~sender_rush;
    gap = sender_rush ? 0 : $urandom_range(18, 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_command     <= cmd;
    in_item_value  <= item;
    in_entry_index <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_command(cmd, item, idx);
    words_sent++;
  endtask

  // One random word. Inserts mostly carry random items, now and then a
  // zero or an extreme one; removes mostly name a live slot and otherwise
  // any index, which covers the sentinel and free slots.
  task automatic send_random_word(input int insert_pct);
    logic [31:0] item;
    logic [7:0]  idx;
    int          pick;
    idx = 8'($urandom_range(255, 0));
    if ($urandom_range(99, 0) < insert_pct) begin
      pick = $urandom_range(19, 0);
      if (pick == 0) item = 32'd0;
      else if (pick == 1) item = 32'hFFFF_FFFF;
      else if (pick == 2) item = 32'd1 << $urandom_range(31, 0);
      else item = $urandom;
      send_word(CMD_INSERT, item, idx);
    end else begin
      item = $urandom;
      if ($urandom_range(99, 0) < 80) begin
        if (!board.pick_live_slot(idx)) idx = 8'($urandom_range(255, 0));
      end
      send_word(CMD_REMOVE, item, idx);
    end
  endtask

  // Result side: stalls a random number of cycles, then takes the next
  // word and hands it to the scoreboard.
  initial begin
    int hold;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if ($urandom_range(39, 0) == 0) receiver_rush = ~receiver_rush;
      hold = receiver_rush ? 0 : $urandom_range(18, 0);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      board.check_reply(out_status, out_slot_index, out_removed_item);
    end
  end

  // Hang detector: counts cycles in which neither channel moves a word.
  initial begin
    int idle;
    idle = 0;
    while (idle < HANG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
      else idle++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin
    int phase;
    int phase_words;
    int saturated;
    board         = new();
    sender_rush   = 1'b0;
    receiver_rush = 1'b0;
    words_sent    = 0;

    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_command     <= CMD_INSERT;
    in_item_value  <= 32'd0;
    in_entry_index <= 8'd0;
    out_stall      <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. On the empty table, removing the sentinel, the first
    // free slot or the last slot must all report a slot that is not live,
    // and a zero item must be refused.
    send_word(CMD_REMOVE, 32'h0000_0001, 8'd0);
    send_word(CMD_REMOVE, 32'd0, 8'd1);
    send_word(CMD_REMOVE, 32'hFFFF_FFFF, 8'd255);
    send_word(CMD_INSERT, 32'd0, 8'd255);
    // Extreme and striped items fill slots 1 to 5 in free-list order.
    send_word(CMD_INSERT, 32'hFFFF_FFFF, 8'd0);
    send_word(CMD_INSERT, 32'h0000_0001, 8'hAA);
    send_word(CMD_INSERT, 32'h8000_0000, 8'h55);
    send_word(CMD_INSERT, 32'h5555_5555, 8'd0);
    send_word(CMD_INSERT, 32'hAAAA_AAAA, 8'd0);
    // The sentinel stays dead while the list holds entries.
    send_word(CMD_REMOVE, 32'd0, 8'd0);
    // Unlink from the middle, then try the same slot again.
    send_word(CMD_REMOVE, 32'd0, 8'd3);
    send_word(CMD_REMOVE, 32'd0, 8'd3);
    // The freed slot is reused first.
    send_word(CMD_INSERT, 32'h1234_5678, 8'd3);
    // Unlink the tail and the head of the list.
    send_word(CMD_REMOVE, 32'd0, 8'd1);
    send_word(CMD_REMOVE, 32'hFFFF_FFFF, 8'd3);
    send_word(CMD_INSERT, 32'd0, 8'd7);
    send_word(CMD_REMOVE, 32'd0, 8'd200);
    send_word(CMD_REMOVE, 32'd0, 8'd2);
    send_word(CMD_REMOVE, 32'd0, 8'd4);
    send_word(CMD_REMOVE, 32'd0, 8'd5);
    // The list is empty again: removing any slot now fails.
    send_word(CMD_REMOVE, 32'd0, 8'd5);
    send_word(CMD_INSERT, 32'h0000_00FF, 8'd0);

    // Random part in phases. A fill phase inserts mostly, until the table
    // has reported full several times; a drain phase removes mostly, until
    // the table has sat empty for a while; a mixed phase keeps the list at
    // a middle size so that unlinks hit head, tail and middle slots.
    // From here on only the random words are counted.
    words_sent  = 0;
    phase       = 0;
    phase_words = 0;
    saturated   = 0;
    while (words_sent < RANDOM_WORDS) begin
      case (phase)
        0: begin
          if (board.live_count == LAST_SLOT) saturated++;
          send_random_word(90);
        end
        1: begin
          if (board.live_count == 0) saturated++;
          send_random_word(12);
        end
        default: begin
          send_random_word(50);
        end
      endcase
      phase_words++;
      if ((phase != 2 && saturated >= 5) || phase_words >= 600 ||
          (phase == 2 && phase_words >= 150)) begin
        phase       = (phase + 1) % 3;
        phase_words = 0;
        saturated   = 0;
      end
    end
    in_valid <= 1'b0;

    // Wait for every reply, then a few cycles more for a stray word.
    while (board.pending_replies.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (board.failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
